>>> hdl/rbt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Record block table package
// Shared constants, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rbt_pkg;

    localparam int SLOTS_DEF        = 128;
    localparam int PAYLOAD_BITS_DEF = 64;

    localparam int MODE_W   = 3;
    localparam int KEY_W    = 32;
    localparam int PAY_IN_W = 64;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 7;
    localparam int COUNT_W  = 8;
    localparam int LIMIT_W  = 8;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd128;

    localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_UPDATE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DELETE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_COMPACT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_COUNT   = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;       // latch item, register match and free vectors
        logic exec;       // apply a key operation and post its result
        logic comp_rd;    // read source slot of the compaction walk
        logic comp_wr;    // move source slot down, advance walk
        logic comp_done;  // post compaction result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_compact;
        logic src_last;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

>>> hdl/rbt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Record block table controller
// Sequences accept, execute and the compaction walk.
// ----------------------------------------------------------------------------
module rbt_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire rbt_pkg::t_stat i_stat,
    output rbt_pkg::t_cmd     o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_CRD   = 3'd2;
    localparam logic [2:0] S_CWR   = 3'd3;
    localparam logic [2:0] S_CDONE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.is_compact) begin
                    n_state = S_CRD;
                end else if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_CRD: begin
                o_cmd.comp_rd = 1'b1;
                n_state       = S_CWR;
            end
            S_CWR: begin
                o_cmd.comp_wr = 1'b1;
                n_state       = i_stat.src_last ? S_CDONE : S_CRD;
            end
            S_CDONE: begin
                if (i_stat.out_free) begin
                    o_cmd.comp_done = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

>>> hdl/rbt_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Record block table datapath
// Slot storage, parallel key compare, priority pick and result register.
// ----------------------------------------------------------------------------
module rbt_datapath #(
    parameter int SLOTS        = rbt_pkg::SLOTS_DEF,
    parameter int PAYLOAD_BITS = rbt_pkg::PAYLOAD_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [rbt_pkg::LIMIT_W-1:0]      i_cfg_wr_data,
    input  wire logic [rbt_pkg::MODE_W-1:0]       i_mode,
    input  wire logic signed [rbt_pkg::KEY_W-1:0] i_record_key,
    input  wire logic [rbt_pkg::PAY_IN_W-1:0]     i_payload,
    input  wire rbt_pkg::t_cmd                    i_cmd,
    output rbt_pkg::t_stat                        o_stat,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [rbt_pkg::STATUS_W-1:0]          o_status,
    output logic [rbt_pkg::INDEX_W-1:0]           o_slot_index,
    output logic [rbt_pkg::COUNT_W-1:0]           o_live_count
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    typedef logic [IW-1:0] t_idx;

    logic [rbt_pkg::LIMIT_W-1:0]  r_limit;
    logic [SLOTS-1:0]             r_valid;
    logic [rbt_pkg::KEY_W-1:0]    r_key_arr [SLOTS];
    logic [PAYLOAD_BITS-1:0]      r_pay_mem [SLOTS];
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                n_count;

    logic [rbt_pkg::MODE_W-1:0]   r_mode;
    logic [rbt_pkg::KEY_W-1:0]    r_key;
    logic [PAYLOAD_BITS-1:0]      r_pay;
    logic [SLOTS-1:0]             r_match;
    logic [SLOTS-1:0]             r_free;

    t_idx                         r_src;
    t_idx                         r_dst;
    logic [rbt_pkg::KEY_W-1:0]    r_mv_key;
    logic [PAYLOAD_BITS-1:0]      r_mv_pay;

    logic                         r_o_valid;
    logic [rbt_pkg::STATUS_W-1:0] r_o_status;
    logic [rbt_pkg::INDEX_W-1:0]  r_o_index;
    logic [rbt_pkg::COUNT_W-1:0]  r_o_count;

    // lowest set bit
    function automatic t_idx pick_low(input logic [SLOTS-1:0] v);
        t_idx r;
        r = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (v[i]) r = t_idx'(i);
        end
        return r;
    endfunction

    t_idx pick_free;
    t_idx pick_hit;
    logic has_free;
    logic has_hit;

    assign pick_free = pick_low(r_free);
    assign pick_hit  = pick_low(r_match);
    assign has_free  = |r_free;
    assign has_hit   = |r_match;

    // storage write controls
    logic                      key_we;
    t_idx                      key_wa;
    logic [rbt_pkg::KEY_W-1:0] key_wd;
    logic                      mem_we;
    t_idx                      mem_wa;
    logic [PAYLOAD_BITS-1:0]   mem_wd;
    logic [SLOTS-1:0]          n_valid;
    logic                      res_we;
    logic [rbt_pkg::STATUS_W-1:0] res_status;
    t_idx                      res_idx;
    logic                      moving;

    assign moving = r_valid[r_src] && (r_dst != r_src);

    always_comb begin
        key_we     = 1'b0;
        key_wa     = r_dst;
        key_wd     = r_mv_key;
        mem_we     = 1'b0;
        mem_wa     = r_dst;
        mem_wd     = r_mv_pay;
        n_valid    = r_valid;
        n_count    = r_count;
        res_we     = 1'b0;
        res_status = rbt_pkg::ST_OK;
        res_idx    = '0;
        if (i_cmd.exec) begin
            res_we = 1'b1;
            case (r_mode)
                rbt_pkg::MODE_INSERT: begin
                    if (has_free) begin
                        n_valid[pick_free] = 1'b1;
                        key_we  = 1'b1;
                        key_wa  = pick_free;
                        key_wd  = r_key;
                        mem_we  = 1'b1;
                        mem_wa  = pick_free;
                        mem_wd  = r_pay;
                        n_count = r_count + CW'(1);
                        res_idx = pick_free;
                    end else begin
                        res_status = rbt_pkg::ST_FULL;
                    end
                end
                rbt_pkg::MODE_LOOKUP, rbt_pkg::MODE_UPDATE, rbt_pkg::MODE_DELETE: begin
                    if (has_hit) begin
                        res_idx = pick_hit;
                        if (r_mode == rbt_pkg::MODE_UPDATE) begin
                            mem_we = 1'b1;
                            mem_wa = pick_hit;
                            mem_wd = r_pay;
                        end else if (r_mode == rbt_pkg::MODE_DELETE) begin
                            n_valid[pick_hit] = 1'b0;
                            n_count = r_count - CW'(1);
                        end
                    end else begin
                        res_status = rbt_pkg::ST_NOT_FOUND;
                    end
                end
                rbt_pkg::MODE_CLEAR: begin
                    n_valid = '0;
                    n_count = '0;
                end
                default: ;
            endcase
        end
        if (i_cmd.comp_wr && moving) begin
            key_we         = 1'b1;
            mem_we         = 1'b1;
            n_valid[r_dst] = 1'b1;
            n_valid[r_src] = 1'b0;
        end
        if (i_cmd.comp_done) begin
            res_we = 1'b1;
        end
    end

    assign o_stat.is_compact = (r_mode == rbt_pkg::MODE_COMPACT);
    assign o_stat.src_last   = (r_src == t_idx'(SLOTS - 1));
    assign o_stat.out_free   = !r_o_valid || !i_out_stall;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= rbt_pkg::LIMIT_RESET;
            r_valid   <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_limit <= i_cfg_wr_data;
            r_valid <= n_valid;
            r_count <= n_count;
            if (res_we) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // item latch and registered compare vectors
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_key  <= i_record_key;
            r_pay  <= i_payload[PAYLOAD_BITS-1:0];
            r_src  <= '0;
            r_dst  <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_match[i] <= r_valid[i] && (r_key_arr[i] == i_record_key);
                r_free[i]  <= !r_valid[i] && (i < int'(r_limit));
            end
        end
        if (i_cmd.comp_rd) begin
            r_mv_key <= r_key_arr[r_src];
        end
        if (i_cmd.comp_wr) begin
            r_src <= r_src + t_idx'(1);
            if (r_valid[r_src]) r_dst <= r_dst + t_idx'(1);
        end
        if (res_we) begin
            r_o_status <= res_status;
            r_o_index  <= rbt_pkg::INDEX_W'(res_idx);
            r_o_count  <= (int'(n_count) > 255) ? 8'd255 : rbt_pkg::COUNT_W'(n_count);
        end
    end

    // key storage
    always_ff @(posedge i_clk) begin
        if (key_we) r_key_arr[key_wa] <= key_wd;
    end

    // payload memory
    always_ff @(posedge i_clk) begin
        if (mem_we) r_pay_mem[mem_wa] <= mem_wd;
        if (i_cmd.comp_rd) r_mv_pay <= r_pay_mem[r_src];
    end

    assign o_out_valid  = r_o_valid;
    assign o_status     = r_o_status;
    assign o_slot_index = r_o_index;
    assign o_live_count = r_o_count;

endmodule
`default_nettype wire

>>> hdl/record_block_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Record block table
// Keyed record slots with first-fit insert, lookup, update, delete,
// compaction, clear and live count.
// ----------------------------------------------------------------------------
// Insert, lookup, update, delete, clear, count and the unused mode: the
// accept cycle compares the key against every slot in parallel and
// registers the match and free vectors, and the execute state then picks
// the lowest set bit and updates the table. Compact walks every slot through
// the payload memory port, in a read state and a write state per slot, after
// the accept and decode states and before a done state that posts its
// result. A finished result waits in the output register while the next
// item is accepted; an item only stalls in its last cycle if that register
// is still held. The user must write the usable slot limit through
// i_cfg_wr_en and i_cfg_wr_data only while the block is idle (not enforced).
module record_block_table_top #(
    parameter int SLOTS        = rbt_pkg::SLOTS_DEF,
    parameter int PAYLOAD_BITS = rbt_pkg::PAYLOAD_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [rbt_pkg::LIMIT_W-1:0]      i_cfg_wr_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [rbt_pkg::MODE_W-1:0]       i_mode,
    input  wire logic signed [rbt_pkg::KEY_W-1:0] i_record_key,
    input  wire logic [rbt_pkg::PAY_IN_W-1:0]     i_payload,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [rbt_pkg::STATUS_W-1:0]          o_status,
    output logic [rbt_pkg::INDEX_W-1:0]           o_slot_index,
    output logic [rbt_pkg::COUNT_W-1:0]           o_live_count
);

    rbt_pkg::t_cmd  cmd;
    rbt_pkg::t_stat stat;

    // sequence each item
    rbt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // hold the table and the result register
    rbt_datapath #(
        .SLOTS        (SLOTS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_mode        (i_mode),
        .i_record_key  (i_record_key),
        .i_payload     (i_payload),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_slot_index  (o_slot_index),
        .o_live_count  (o_live_count)
    );

endmodule
`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Record block table testbench
// Drives insert, lookup, update, delete, compact, clear and count items under
// several usable-slot limits and idling patterns, and checks every result
// against a behavioral copy of the table.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NSLOT    = 128;
    localparam int WDOG_MAX = 20000;
    // Mode code with no operation behind it.
    localparam logic [rbt_pkg::MODE_W-1:0] MODE_SPARE = 3'd7;

    typedef struct packed {
        logic [rbt_pkg::STATUS_W-1:0] status;
        logic [rbt_pkg::INDEX_W-1:0]  slot;
        logic [rbt_pkg::COUNT_W-1:0]  count;
    } t_answer;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_wr_en = 1'b0;
    logic [rbt_pkg::LIMIT_W-1:0]  cfg_wr_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [rbt_pkg::MODE_W-1:0]   mode = rbt_pkg::MODE_COUNT;
    logic signed [rbt_pkg::KEY_W-1:0] rec_key = '0;
    logic [rbt_pkg::PAY_IN_W-1:0] payload = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [rbt_pkg::STATUS_W-1:0] status;
    logic [rbt_pkg::INDEX_W-1:0]  slot_index;
    logic [rbt_pkg::COUNT_W-1:0]  live_count;

    // Shadow copy of the table.
    logic                         tbl_valid [NSLOT];
    logic [rbt_pkg::KEY_W-1:0]    tbl_key   [NSLOT];
    logic [rbt_pkg::PAY_IN_W-1:0] tbl_pay   [NSLOT];
    int                           tbl_total;
    int                           tbl_limit;

    t_answer answer_q[$];
    int      mismatches = 0;
    int      results_seen = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      quiet_cycles = 0;
    int      items_sent = 0;
    // Keys recently inserted, so that matches are common.
    logic [rbt_pkg::KEY_W-1:0] key_pool[$];

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    record_block_table_top i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_mode(mode), .i_record_key(rec_key), .i_payload(payload),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_status(status), .o_slot_index(slot_index), .o_live_count(live_count)
    );

    // Apply one operation to the shadow table and return its answer.
    function automatic t_answer table_apply(logic [rbt_pkg::MODE_W-1:0] m,
                                            logic [rbt_pkg::KEY_W-1:0] k,
                                            logic [rbt_pkg::PAY_IN_W-1:0] d);
        t_answer a;
        int hit;
        int dst;
        a = '{status: rbt_pkg::ST_OK, slot: '0, count: '0};
        hit = -1;
        case (m)
            rbt_pkg::MODE_INSERT: begin
                for (int i = 0; i < tbl_limit; i++) begin
                    if (!tbl_valid[i] && hit < 0) hit = i;
                end
                if (hit < 0) begin
                    a.status = rbt_pkg::ST_FULL;
                end else begin
                    tbl_valid[hit] = 1'b1;
                    tbl_key[hit] = k;
                    tbl_pay[hit] = d;
                    tbl_total++;
                    a.slot = hit[rbt_pkg::INDEX_W-1:0];
                end
            end
            rbt_pkg::MODE_LOOKUP, rbt_pkg::MODE_UPDATE, rbt_pkg::MODE_DELETE: begin
                for (int i = NSLOT - 1; i >= 0; i--) begin
                    if (tbl_valid[i] && tbl_key[i] == k) hit = i;
                end
                if (hit < 0) begin
                    a.status = rbt_pkg::ST_NOT_FOUND;
                end else begin
                    if (m == rbt_pkg::MODE_UPDATE) tbl_pay[hit] = d;
                    if (m == rbt_pkg::MODE_DELETE) begin
                        tbl_valid[hit] = 1'b0;
                        tbl_total--;
                    end
                    a.slot = hit[rbt_pkg::INDEX_W-1:0];
                end
            end
            rbt_pkg::MODE_COMPACT: begin
                dst = 0;
                for (int i = 0; i < NSLOT; i++) begin
                    if (tbl_valid[i]) begin
                        if (dst != i) begin
                            tbl_valid[dst] = 1'b1;
                            tbl_key[dst] = tbl_key[i];
                            tbl_pay[dst] = tbl_pay[i];
                            tbl_valid[i] = 1'b0;
                        end
                        dst++;
                    end
                end
            end
            rbt_pkg::MODE_CLEAR: begin
                for (int i = 0; i < NSLOT; i++) tbl_valid[i] = 1'b0;
                tbl_total = 0;
            end
            default: ;
        endcase
        a.count = tbl_total[rbt_pkg::COUNT_W-1:0];
        return a;
    endfunction

    // Send one item; hold it until accepted, then record its answer.
    // Valid stays up after the accept; the next item, an idle cycle or a
    // drain replaces or drops it at the same edge.
    task automatic send_item(logic [rbt_pkg::MODE_W-1:0] m,
                             logic [rbt_pkg::KEY_W-1:0] k,
                             logic [rbt_pkg::PAY_IN_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        rec_key <= k;
        payload <= d;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        answer_q.push_back(table_apply(m, k, d));
        if (m == rbt_pkg::MODE_INSERT) key_pool.push_back(k);
        if (key_pool.size() > 40) void'(key_pool.pop_front());
        items_sent++;
    endtask

    // Drop valid and hold off until every result is back, plus a margin
    // for a compaction walk.
    task automatic drain();
        in_valid <= 1'b0;
        while (answer_q.size() != 0) @(posedge clk);
        repeat (2 * NSLOT + 10) @(posedge clk);
    endtask

    task automatic set_limit(int lim);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= lim[rbt_pkg::LIMIT_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tbl_limit = (lim < NSLOT) ? lim : NSLOT;
    endtask

    // Receiver: stall at random, compare each accepted result.
    always @(posedge clk) begin
        t_answer want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                results_seen++;
                if (answer_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result status=%0d slot=%0d count=%0d",
                                 status, slot_index, live_count);
                end else begin
                    want = answer_q.pop_front();
                    if (status !== want.status || slot_index !== want.slot ||
                        live_count !== want.count) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                     results_seen, want.status, want.slot, want.count,
                                     status, slot_index, live_count);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: count cycles with no handshake on either side.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [rbt_pkg::KEY_W-1:0] pick_key();
        if (key_pool.size() != 0 && $urandom_range(99) < 75)
            return key_pool[$urandom_range(key_pool.size() - 1)];
        return $urandom_range(7) == 0 ? $urandom() : rbt_pkg::KEY_W'($urandom_range(15));
    endfunction

    function automatic logic [rbt_pkg::PAY_IN_W-1:0] rand_pay();
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_directed();
        send_item(rbt_pkg::MODE_COUNT, '0, '0);
        send_item(rbt_pkg::MODE_LOOKUP, 32'h8000_0000, '0);
        send_item(rbt_pkg::MODE_INSERT, 32'h8000_0000, '1);
        send_item(rbt_pkg::MODE_INSERT, 32'h7FFF_FFFF, '0);
        send_item(rbt_pkg::MODE_INSERT, 32'hFFFF_FFFF, 64'hA5A5_5A5A_F0F0_0F0F);
        send_item(rbt_pkg::MODE_INSERT, 32'h7FFF_FFFF, 64'h1);
        send_item(rbt_pkg::MODE_LOOKUP, 32'h7FFF_FFFF, '0);
        send_item(rbt_pkg::MODE_UPDATE, 32'hFFFF_FFFF, '1);
        send_item(rbt_pkg::MODE_UPDATE, 32'h1234_5678, '1);
        send_item(rbt_pkg::MODE_DELETE, 32'h8000_0000, '0);
        send_item(rbt_pkg::MODE_DELETE, 32'h8000_0000, '0);
        send_item(rbt_pkg::MODE_LOOKUP, 32'h7FFF_FFFF, '0);
        send_item(rbt_pkg::MODE_COMPACT, '0, '0);
        send_item(rbt_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, '0);
        send_item(MODE_SPARE, '1, '1);
        send_item(rbt_pkg::MODE_CLEAR, '0, '0);
        send_item(rbt_pkg::MODE_COUNT, '1, '1);
    endtask

    // Fill a small window, then lower the limit below the live entries.
    task automatic test_limits();
        set_limit(2);
        for (int i = 0; i < 4; i++) send_item(rbt_pkg::MODE_INSERT, i, rand_pay());
        set_limit(0);
        send_item(rbt_pkg::MODE_INSERT, 32'd9, '0);
        send_item(rbt_pkg::MODE_LOOKUP, 32'd1, '0);
        send_item(rbt_pkg::MODE_DELETE, 32'd0, '0);
        send_item(rbt_pkg::MODE_COMPACT, '0, '0);
        send_item(rbt_pkg::MODE_LOOKUP, 32'd1, '0);
        set_limit(255);
        send_item(rbt_pkg::MODE_CLEAR, '0, '0);
    endtask

    task automatic test_random(int n, int lim);
        int r;
        logic [rbt_pkg::MODE_W-1:0] m;
        set_limit(lim);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 40)      m = rbt_pkg::MODE_INSERT;
            else if (r < 55) m = rbt_pkg::MODE_LOOKUP;
            else if (r < 67) m = rbt_pkg::MODE_UPDATE;
            else if (r < 87) m = rbt_pkg::MODE_DELETE;
            else if (r < 90) m = rbt_pkg::MODE_COMPACT;
            else if (r < 92) m = rbt_pkg::MODE_CLEAR;
            else if (r < 97) m = rbt_pkg::MODE_COUNT;
            else             m = MODE_SPARE;
            send_item(m, pick_key(), rand_pay());
            // Let the pipeline empty once, halfway through, before continuing.
            if (i == n / 2) drain();
        end
    endtask

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i] = '0;
            tbl_pay[i] = '0;
        end
        tbl_total = 0;
        tbl_limit = NSLOT;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_limits();
        // Sweep idling patterns and limits, extremes included.
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random(350, 128);
        send_idle_pct = 62; recv_stall_pct = 0;  test_random(350, 1);
        send_idle_pct = 0;  recv_stall_pct = 62; test_random(350, 16);
        send_idle_pct = 27; recv_stall_pct = 27; test_random(350, 200);
        send_idle_pct = 0;  recv_stall_pct = 0;

        drain();
        $display("Sent %0d items over limits 0..255, checked %0d results.",
                 items_sent, results_seen);
        if (mismatches == 0 && answer_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

>>> files.f
hdl/rbt_pkg.sv
hdl/rbt_ctrl.sv
hdl/rbt_datapath.sv
hdl/record_block_table_top.sv
dv/testbench.sv
